// ===== sv/int8_mac_requantize_unit_assert.svh =====
// assertion helpers, used inside modules that have clk and rst_n
`ifndef INT8_MAC_REQUANTIZE_UNIT_ASSERT_SVH
`define INT8_MAC_REQUANTIZE_UNIT_ASSERT_SVH

// same-cycle implication
`define IMR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IMR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/imr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package imr_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 31;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_INPUT_OFFSET   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MULTIPLIER     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_SHIFT          = 3'd2;
  localparam logic [CFG_AW-1:0] REG_OUT_ZERO_POINT = 3'd3;
  localparam logic [CFG_AW-1:0] REG_RELU_MODE      = 3'd4;

  // reset values
  localparam logic [7:0]  RST_INPUT_OFFSET   = 8'd0;
  localparam logic [30:0] RST_MULTIPLIER     = 31'd1158164864;
  localparam logic [4:0]  RST_SHIFT          = 5'd1;
  localparam logic [7:0]  RST_OUT_ZERO_POINT = 8'h80;
  localparam logic        RST_RELU_MODE      = 1'b1;

  // controller commands to the datapath
  typedef struct packed {
    logic acc_en;
    logic mul_en;
    logic shf_en;
    logic out_load;
  } imr_cmd_t;

endpackage

`default_nettype wire

// ===== sv/imr_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface imr_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] activation;
  logic signed [7:0] weight;
  logic signed [31:0] bias;
  logic              first;
  logic              last;

  modport source (output valid, output activation, output weight, output bias,
                  output first, output last, input ready);
  modport sink (input valid, input activation, input weight, input bias,
                input first, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/imr_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface imr_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] result;

  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

`default_nettype wire

// ===== sv/imr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "int8_mac_requantize_unit_assert.svh"

module imr_ctrl
  import imr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_last,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output imr_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_SHF  = 4'b0100,
    ST_CLP  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.acc_en   = accept;
    cmd.mul_en   = (state_r == ST_MUL);
    cmd.shf_en   = (state_r == ST_SHF);
    cmd.out_load = (state_r == ST_CLP) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_last) state_nxt = ST_MUL;
      end
      ST_MUL:  state_nxt = ST_SHF;
      ST_SHF:  state_nxt = ST_CLP;
      ST_CLP: begin
        if (cmd.out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `IMR_ASSERT_NXT(a_last_starts_req, accept && in_last, state_r == ST_MUL, "last beat did not start requantize")
  `IMR_ASSERT_NXT(a_mul_to_shf, state_r == ST_MUL, state_r == ST_SHF, "multiply stage did not advance")
  `IMR_ASSERT_NOW(a_valid_rise_src, $rose(out_valid_r), $past(state_r == ST_CLP), "result shown without clamp stage")
  `IMR_ASSERT_NXT(a_clp_waits, (state_r == ST_CLP) && out_valid_r && !out_ready, state_r == ST_CLP, "clamp stage overwrote a waiting result")

endmodule

`default_nettype wire

// ===== sv/imr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module imr_datapath
  import imr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire imr_cmd_t           cmd,
  input  wire logic signed [7:0]  activation,
  input  wire logic signed [7:0]  weight,
  input  wire logic signed [31:0] bias,
  input  wire logic               first,
  input  wire logic               cfg_we,
  input  wire logic [CFG_AW-1:0]  cfg_addr,
  input  wire logic [CFG_DW-1:0]  cfg_wdata,
  output logic signed [7:0]       result
);

  logic [7:0]         in_off_r;
  logic [30:0]        mult_r;
  logic [4:0]         shift_r;
  logic signed [7:0]  zp_r;
  logic               relu_r;

  logic signed [31:0] acc_r, acc_nxt;
  logic signed [62:0] prod_r, prod_nxt;
  logic signed [32:0] shf_r, shf_nxt;
  logic signed [7:0]  result_r, result_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_off_r <= RST_INPUT_OFFSET;
      mult_r   <= RST_MULTIPLIER;
      shift_r  <= RST_SHIFT;
      zp_r     <= RST_OUT_ZERO_POINT;
      relu_r   <= RST_RELU_MODE;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_INPUT_OFFSET:   in_off_r <= cfg_wdata[7:0];
        REG_MULTIPLIER:     mult_r   <= cfg_wdata[30:0];
        REG_SHIFT:          shift_r  <= cfg_wdata[4:0];
        REG_OUT_ZERO_POINT: zp_r     <= cfg_wdata[7:0];
        REG_RELU_MODE:      relu_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // mac: (act - offset) * weight into the wrapping accumulator
  logic signed [9:0]  act_off;
  logic signed [17:0] act_ext, wgt_ext, mac_prod;
  logic signed [31:0] acc_base;

  always_comb begin
    act_off  = $signed({{2{activation[7]}}, activation}) - $signed({2'b00, in_off_r});
    act_ext  = {{8{act_off[9]}}, act_off};
    wgt_ext  = {{10{weight[7]}}, weight};
    mac_prod = act_ext * wgt_ext;
    acc_base = first ? bias : acc_r;
    acc_nxt  = acc_base + {{14{mac_prod[17]}}, mac_prod};
  end

  // q31 multiply
  logic signed [63:0] mul_full;

  always_comb begin
    mul_full = acc_r * $signed({1'b0, mult_r});
    prod_nxt = mul_full[62:0];
  end

  // floor by 2^31, then rounding right shift
  logic signed [32:0] hi_ext, rnd_c, rnd_sum;
  logic [4:0]         shift_m1;

  always_comb begin
    hi_ext   = {prod_r[62], prod_r[62:31]};
    shift_m1 = shift_r - 5'd1;
    rnd_c    = 33'sd1 <<< shift_m1;
    rnd_sum  = hi_ext + rnd_c;
    shf_nxt  = (shift_r == 5'd0) ? hi_ext : (rnd_sum >>> shift_r);
  end

  // zero point and clamp
  logic signed [33:0] zp_sum, lo_bound;

  always_comb begin
    zp_sum   = {shf_r[32], shf_r} + {{26{zp_r[7]}}, zp_r};
    lo_bound = relu_r ? 34'sd0 : -34'sd128;
    if (zp_sum > 34'sd127) begin
      result_nxt = 8'sd127;
    end else if (zp_sum < lo_bound) begin
      result_nxt = lo_bound[7:0];
    end else begin
      result_nxt = zp_sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en)   prod_r   <= prod_nxt;
    if (cmd.shf_en)   shf_r    <= shf_nxt;
    if (cmd.out_load) result_r <= result_nxt;
  end

  assign result = result_r;

endmodule

`default_nettype wire

// ===== sv/int8_mac_requantize_unit.sv =====
// int8 multiply-accumulate with q31 requantize. every input beat adds
// (activation - input_offset) * weight into a 32-bit wrapping accumulator
// (first loads bias plus the product); a beat with last also produces one
// int8 result beat. after a beat without last the next beat can follow right
// behind it. a beat with last holds off the next beat until its steps are
// done: accumulate, q31 multiply, rounding shift, then zero point and clamp
// into the output register; the last step waits while an earlier result still
// sits unread there. that sequence through the single requantize path sets
// the rate. configuration is written through cfg_we / cfg_addr / cfg_wdata;
// the user must write it only while the unit is idle; nothing enforces it.
`timescale 1ns / 1ps
`default_nettype none

module int8_mac_requantize_unit
  import imr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  imr_in_if.sink                 in_ch,
  imr_out_if.source              out_ch,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  // command bundle from the sequencer
  imr_cmd_t cmd;

  // sequencer: beat acceptance, requantize steps, output handshake
  imr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // arithmetic: config registers, accumulator, multiply, shift, clamp
  imr_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .activation (in_ch.activation),
    .weight     (in_ch.weight),
    .bias       (in_ch.bias),
    .first      (in_ch.first),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .result     (out_ch.result)
  );

endmodule

`default_nettype wire
